// ===== hdl/grid_local_minimum_risk_sum_top_defines.svh =====
// Assertion macros shared by the grid local minimum risk sum RTL.
`ifndef GRID_LOCAL_MINIMUM_RISK_SUM_TOP_DEFINES_SVH
`define GRID_LOCAL_MINIMUM_RISK_SUM_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define GLMRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset
`define GLMRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define GLMRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GLMRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/glmrs_pkg.sv =====
// Types and constants for the grid local minimum risk sum block.
package glmrs_pkg;

  localparam int unsigned HEIGHT_W        = 4;
  localparam int unsigned SUM_W           = 18;
  localparam int unsigned INC_W           = 6;   // up to four minima per beat, each <= 10
  localparam int unsigned CFG_W           = 8;
  localparam int unsigned CFG_RESET_COUNT = 128;

  typedef logic [HEIGHT_W-1:0] height_t;
  typedef logic [SUM_W-1:0]    risk_t;
  typedef logic [INC_W-1:0]    risk_inc_t;
  typedef logic [CFG_W-1:0]    cfg_data_t;

  localparam height_t HEIGHT_CAP = height_t'(9);

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_COLUMN_COUNT = 1'b0,
    CFG_ROW_COUNT    = 1'b1
  } cfg_idx_e;

  // One line store entry: the two rows above the current one
  typedef struct packed {
    height_t two_back;
    height_t one_back;
  } line_entry_t;

  // One grid column as seen by the window: two rows back, one back, current
  typedef struct packed {
    height_t top;
    height_t mid;
    height_t bot;
  } column_t;

  // Position flags of the arriving cell
  typedef struct packed {
    logic first_col;   // column 0
    logic early_col;   // column 0 or 1
    logic last_col;
    logic has_up;      // row >= 1
    logic near_top;    // row < 2
    logic last_row;
  } pos_flags_t;

endpackage

// ===== hdl/glmrs_height_if.sv =====
// Input stream channel carrying one height digit per beat.
interface glmrs_height_if;
  import glmrs_pkg::*;

  logic    valid;
  logic    ready;
  height_t height_value;

  modport source (output valid, output height_value, input ready);
  modport sink   (input valid, input height_value, output ready);
endinterface

// ===== hdl/glmrs_risk_if.sv =====
// Output stream channel carrying one frame risk sum per beat.
interface glmrs_risk_if;
  import glmrs_pkg::*;

  logic  valid;
  logic  ready;
  risk_t risk_sum;

  modport source (output valid, output risk_sum, input ready);
  modport sink   (input valid, input risk_sum, output ready);
endinterface

// ===== hdl/grid_local_minimum_risk_sum_top.sv =====
// Top level: streamed four-neighbor local minimum detection with frame risk sum.
//
//  channel    dir  payload                 handshake
//  height_i   in   height_value [3:0]      valid/ready, one cell per beat
//  risk_o     out  risk_sum [17:0]         valid/ready, one beat per frame
//  cfg        in   cfg_idx_i, cfg_data_i   cfg_we_i, no wait
//
// One cell per cycle unless stalled; the sum is registered on the last beat.
// The line store read of the next column is issued as each beat is taken, so its
// registered data is ready for the following cell without a bubble.
// Reset clears positions, sum and output; the line store is not cleared.
// Input stalls only while a finished sum waits on risk_o.
module grid_local_minimum_risk_sum_top #(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS    = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  glmrs_height_if.sink          height_i,
  glmrs_risk_if.source          risk_o,
  input  logic                  cfg_we_i,
  input  glmrs_pkg::cfg_idx_e   cfg_idx_i,
  input  glmrs_pkg::cfg_data_t  cfg_data_i
);
  import glmrs_pkg::*;

`include "grid_local_minimum_risk_sum_top_defines.svh"

  localparam int unsigned CAW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [CAW-1:0] COL_RST_LAST =
    CAW'(((MAX_COLUMNS < CFG_RESET_COUNT) ? MAX_COLUMNS : CFG_RESET_COUNT) - 1);
  localparam logic [RAW-1:0] ROW_RST_LAST =
    RAW'(((MAX_ROWS < CFG_RESET_COUNT) ? MAX_ROWS : CFG_RESET_COUNT) - 1);

  logic [CAW-1:0] col_q, col_d, last_col_q, last_col_d;
  logic [RAW-1:0] row_q, row_d, last_row_q, last_row_d;
  risk_t          run_q, run_d;
  logic           out_valid_q, out_valid_d;
  risk_t          out_sum_q;

  logic           in_fire, last_cell;
  height_t        height_sat;
  line_entry_t    line_rd, line_wr;
  column_t        cur_col, prev_col, prev2_col;
  pos_flags_t     flags;
  risk_inc_t      inc;
  logic [SUM_W:0] sum_wide;
  risk_t          sum_sat;

  // Handshake: the output register decouples the two sides
  assign height_i.ready = !out_valid_q || risk_o.ready;
  assign in_fire        = height_i.valid && height_i.ready;

  assign height_sat = (height_i.height_value > HEIGHT_CAP) ? HEIGHT_CAP
                                                           : height_i.height_value;

  // Position flags
  always_comb begin
    flags.first_col = (col_q == '0);
    flags.early_col = (col_q <= CAW'(1));
    flags.last_col  = (col_q == last_col_q);
    flags.has_up    = (row_q != '0);
    flags.near_top  = (row_q <= RAW'(1));
    flags.last_row  = (row_q == last_row_q);
  end
  assign last_cell = flags.last_col && flags.last_row;

  // Line store: shift the column down one row on each beat
  assign line_wr.two_back = line_rd.one_back;
  assign line_wr.one_back = height_sat;

  glmrs_line_store #(
    .DEPTH (MAX_COLUMNS),
    .AW    (CAW)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (col_q),
    .wdata_i (line_wr),
    .raddr_i (col_d),
    .rdata_o (line_rd)
  );

  // Window chain: columns c-1 and c-2
  assign cur_col.top = line_rd.two_back;
  assign cur_col.mid = line_rd.one_back;
  assign cur_col.bot = height_sat;

  glmrs_col_cell u_cell0 (
    .clk_i   (clk_i),
    .shift_i (in_fire),
    .col_i   (cur_col),
    .col_o   (prev_col)
  );

  glmrs_col_cell u_cell1 (
    .clk_i   (clk_i),
    .shift_i (in_fire),
    .col_i   (prev_col),
    .col_o   (prev2_col)
  );

  glmrs_min_judge u_judge (
    .flags_i (flags),
    .cur_i   (cur_col),
    .prev_i  (prev_col),
    .prev2_i (prev2_col),
    .inc_o   (inc)
  );

  // Saturating accumulate
  assign sum_wide = {1'b0, run_q} + (SUM_W + 1)'(inc);
  assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

  // Configuration: clamp counts to 1..MAX, store last index
  always_comb begin
    last_col_d = last_col_q;
    last_row_d = last_row_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLUMN_COUNT: begin
          if (cfg_data_i == '0) begin
            last_col_d = '0;
          end else if (32'(cfg_data_i) > MAX_COLUMNS) begin
            last_col_d = CAW'(MAX_COLUMNS - 1);
          end else begin
            last_col_d = CAW'(cfg_data_i - cfg_data_t'(1));
          end
        end
        CFG_ROW_COUNT: begin
          if (cfg_data_i == '0) begin
            last_row_d = '0;
          end else if (32'(cfg_data_i) > MAX_ROWS) begin
            last_row_d = RAW'(MAX_ROWS - 1);
          end else begin
            last_row_d = RAW'(cfg_data_i - cfg_data_t'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Raster position and running sum
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    run_d = run_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
      run_d = '0;
    end else if (in_fire) begin
      if (flags.last_col) begin
        col_d = '0;
        row_d = flags.last_row ? '0 : row_q + RAW'(1);
      end else begin
        col_d = col_q + CAW'(1);
      end
      run_d = last_cell ? '0 : sum_sat;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && last_cell) begin
      out_valid_d = 1'b1;
    end else if (risk_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      run_q       <= '0;
      last_col_q  <= COL_RST_LAST;
      last_row_q  <= ROW_RST_LAST;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      run_q       <= run_d;
      last_col_q  <= last_col_d;
      last_row_q  <= last_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_cell) begin
      out_sum_q <= sum_sat;
    end
  end

  assign risk_o.valid    = out_valid_q;
  assign risk_o.risk_sum = out_sum_q;

  // Checks
  `GLMRS_ASSERT_IMP(a_pos_in_range, clk_i, rst_ni, 1'b1,
                    (col_q <= last_col_q) && (row_q <= last_row_q))
  `GLMRS_ASSERT_IMP(a_out_from_last_cell, clk_i, rst_ni, $rose(out_valid_q),
                    $past(in_fire && last_cell))
  `GLMRS_ASSERT_NXT(a_col_advance, clk_i, rst_ni, in_fire && !cfg_we_i && !flags.last_col,
                    col_q == CAW'($past(col_q) + CAW'(1)))
  `GLMRS_ASSERT_NXT(a_frame_restart, clk_i, rst_ni, in_fire && !cfg_we_i && last_cell,
                    (run_q == '0) && (col_q == '0) && (row_q == '0) && out_valid_q)

endmodule

// ===== hdl/glmrs_line_store.sv =====
// Line store holding the two prior rows, one entry per column, write-first read.
module glmrs_line_store #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  glmrs_pkg::line_entry_t   wdata_i,
  input  logic [AW-1:0]            raddr_i,
  output glmrs_pkg::line_entry_t   rdata_o
);
  import glmrs_pkg::*;

  line_entry_t mem_q [DEPTH];
  line_entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; a same-address write is forwarded
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/glmrs_col_cell.sv =====
// Window cell: holds one grid column triplet and passes it on each beat.
module glmrs_col_cell (
  input  logic               clk_i,
  input  logic               shift_i,
  input  glmrs_pkg::column_t col_i,
  output glmrs_pkg::column_t col_o
);
  import glmrs_pkg::*;

  column_t col_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

// ===== hdl/glmrs_min_judge.sv =====
// Minimum decisions for one beat: cells that became fully known, summed as height plus one.
module glmrs_min_judge (
  input  glmrs_pkg::pos_flags_t flags_i,
  input  glmrs_pkg::column_t    cur_i,    // column c: two back, one back, arriving
  input  glmrs_pkg::column_t    prev_i,   // column c-1
  input  glmrs_pkg::column_t    prev2_i,  // column c-2
  output glmrs_pkg::risk_inc_t  inc_o
);
  import glmrs_pkg::*;

  logic      take_a, take_b, take_c, take_d;
  risk_inc_t term_a, term_b, term_c, term_d;

  always_comb begin
    // Row above, column c-1: all four neighbors now known
    take_a = flags_i.has_up && !flags_i.first_col
          && (flags_i.early_col || (prev_i.mid < prev2_i.mid))
          && (prev_i.mid < cur_i.mid)
          && (flags_i.near_top || (prev_i.mid < prev_i.top))
          && (prev_i.mid < prev_i.bot);

    // Row above, last column: no right neighbor
    take_b = flags_i.has_up && flags_i.last_col
          && (flags_i.first_col || (cur_i.mid < prev_i.mid))
          && (flags_i.near_top || (cur_i.mid < cur_i.top))
          && (cur_i.mid < cur_i.bot);

    // Last row, column c-1: no lower neighbor
    take_c = flags_i.last_row && !flags_i.first_col
          && (flags_i.early_col || (prev_i.bot < prev2_i.bot))
          && (prev_i.bot < cur_i.bot)
          && (!flags_i.has_up || (prev_i.bot < prev_i.mid));

    // Last row, last column: only left and upper neighbors
    take_d = flags_i.last_row && flags_i.last_col
          && (flags_i.first_col || (cur_i.bot < prev_i.bot))
          && (!flags_i.has_up || (cur_i.bot < cur_i.mid));

    term_a = take_a ? INC_W'(prev_i.mid) + INC_W'(1) : '0;
    term_b = take_b ? INC_W'(cur_i.mid)  + INC_W'(1) : '0;
    term_c = take_c ? INC_W'(prev_i.bot) + INC_W'(1) : '0;
    term_d = take_d ? INC_W'(cur_i.bot)  + INC_W'(1) : '0;
  end

  assign inc_o = term_a + term_b + term_c + term_d;

endmodule

// ===== dv/tb_grid_local_minimum_risk_sum_top.sv =====
// Testbench for the grid local minimum risk sum block: raster height stream in, frame sums checked.
module tb_grid_local_minimum_risk_sum_top;
  timeunit 1ns;
  timeprecision 1ps;

  import glmrs_pkg::*;

  localparam int unsigned MAX_COLUMNS   = 128;
  localparam int unsigned MAX_ROWS      = 128;
  localparam int unsigned SUM_LIMIT     = 262143;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned CELL_TARGET   = 1100;
  localparam int unsigned QUIET_TAIL    = 950;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  cfg_idx_e   cfg_idx_i;
  cfg_data_t  cfg_data_i;

  glmrs_height_if height_ch ();
  glmrs_risk_if   risk_ch ();

  grid_local_minimum_risk_sum_top #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .height_i   (height_ch),
    .risk_o     (risk_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: line stores, row window, positions, running sum, active counts
  int unsigned line_two [MAX_COLUMNS];
  int unsigned line_one [MAX_COLUMNS];
  int unsigned win_near, win_far;
  int unsigned col_at, row_at;
  int unsigned run_sum;
  int unsigned eff_cols, eff_rows;

  height_t     cell_q [$];       // heights waiting to be driven
  risk_t       risk_expect [$];  // frame sums still to come out
  int unsigned cells_issued;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned feed_gap, drain_gap;
  bit          feed_idle_en, drain_idle_en;

  function automatic int unsigned clamp_count(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void restart_frame();
    col_at   = 0;
    row_at   = 0;
    run_sum  = 0;
    win_near = 0;
    win_far  = 0;
  endfunction

  function automatic void apply_register(cfg_idx_e idx, cfg_data_t data);
    case (idx)
      CFG_COLUMN_COUNT: eff_cols = clamp_count(data, MAX_COLUMNS);
      CFG_ROW_COUNT:    eff_rows = clamp_count(data, MAX_ROWS);
      default: ;
    endcase
    restart_frame();
  endfunction

  // Flags are true when that neighbor is absent or higher
  function automatic void add_if_min(int unsigned m, bit lf, bit rt, bit up, bit dn);
    if (lf && rt && up && dn) begin
      run_sum = run_sum + m + 1;
      if (run_sum > SUM_LIMIT) run_sum = SUM_LIMIT;
    end
  endfunction

  // Take one cell; returns 1 with the frame sum when the frame closes
  function automatic bit advance_cell(height_t raw, output risk_t frame_sum);
    int unsigned v, c, r, m;
    bit          last_c, last_r, done;
    v = 32'((raw > HEIGHT_CAP) ? HEIGHT_CAP : raw);
    c = (col_at >= eff_cols) ? eff_cols - 1 : col_at;
    r = (row_at >= eff_rows) ? eff_rows - 1 : row_at;
    last_c = (c + 1 == eff_cols);
    last_r = (r + 1 == eff_rows);
    done = 1'b0;
    frame_sum = '0;
    // cell above the arriving one now has its lower neighbor
    if (r >= 1) begin
      m = line_one[c];
      add_if_min(m, c == 0 || m < line_two[c-1], last_c || m < line_one[c+1],
                 r < 2 || m < line_two[c], m < v);
    end
    // bottom row: cells are decided along the row itself
    if (last_r) begin
      if (c >= 1) begin
        m = win_near;
        add_if_min(m, c < 2 || m < win_far, m < v, r < 1 || m < line_two[c-1], 1'b1);
      end
      if (last_c)
        add_if_min(v, c == 0 || v < win_near, 1'b1, r < 1 || v < line_one[c], 1'b1);
    end
    line_two[c] = line_one[c];
    line_one[c] = v;
    win_far  = win_near;
    win_near = v;
    if (last_c) begin
      if (last_r) begin
        frame_sum = risk_t'(run_sum);
        done = 1'b1;
        restart_frame();
      end else begin
        col_at   = 0;
        row_at   = r + 1;
        win_near = 0;
        win_far  = 0;
      end
    end else begin
      col_at = c + 1;
      row_at = r;
    end
    return done;
  endfunction

  task automatic flag_error(string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Height feed: bursts of idle cycles between beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_ch.valid        <= 1'b0;
      height_ch.height_value <= '0;
      feed_gap               <= 0;
    end else if (!height_ch.valid || height_ch.ready) begin
      if (feed_gap != 0) begin
        height_ch.valid <= 1'b0;
        feed_gap        <= feed_gap - 1;
      end else if (feed_idle_en && $urandom_range(0, 7) == 0) begin
        height_ch.valid <= 1'b0;
        feed_gap        <= $urandom_range(0, 12);
      end else if (cell_q.size() != 0) begin
        height_ch.valid        <= 1'b1;
        height_ch.height_value <= cell_q.pop_front();
      end else begin
        height_ch.valid <= 1'b0;
      end
    end
  end

  // Sum receiver: ready drops in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      risk_ch.ready <= 1'b0;
      drain_gap     <= 0;
    end else if (drain_gap != 0) begin
      risk_ch.ready <= 1'b0;
      drain_gap     <= drain_gap - 1;
    end else if (drain_idle_en && $urandom_range(0, 5) == 0) begin
      risk_ch.ready <= 1'b0;
      drain_gap     <= $urandom_range(0, 12);
    end else begin
      risk_ch.ready <= 1'b1;
    end
  end

  // Monitor: check sum beats, predict from height beats
  always @(posedge clk_i) begin : monitor
    risk_t want;
    risk_t frame_sum;
    if (rst_ni) begin
      if (risk_ch.valid && risk_ch.ready) begin
        if (risk_expect.size() == 0) begin
          flag_error($sformatf("unexpected risk_sum beat, actual %0d", risk_ch.risk_sum));
        end else begin
          want = risk_expect.pop_front();
          if (risk_ch.risk_sum !== want)
            flag_error($sformatf("risk_sum mismatch: expected %0d, actual %0d",
                                 want, risk_ch.risk_sum));
        end
      end
      if (height_ch.valid && height_ch.ready) begin
        if (advance_cell(height_ch.height_value, frame_sum))
          risk_expect = {risk_expect, frame_sum};
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_grid_local_minimum_risk_sum_top failed");
      $finish;
    end
  end

  // Wait until every queued beat is taken and every sum has come out
  task automatic settle();
    do @(posedge clk_i);
    while (cell_q.size() != 0 || height_ch.valid || risk_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, cfg_data_t data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    apply_register(idx, data);
  endtask

  task automatic configure(bit put_cols, cfg_data_t cols, bit put_rows, cfg_data_t rows,
                           bit rows_first);
    settle();
    if (rows_first && put_rows) write_reg(CFG_ROW_COUNT, rows);
    if (put_cols) write_reg(CFG_COLUMN_COUNT, cols);
    if (!rows_first && put_rows) write_reg(CFG_ROW_COUNT, rows);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_cell(height_t h);
    cell_q = {cell_q, h};
    cells_issued++;
  endtask

  // style 0: digits with rare out-of-range, 1: low plateaus, 2: any 4-bit value
  task automatic queue_heights(int unsigned count, int unsigned style);
    height_t h;
    repeat (count) begin
      case (style)
        0:       h = ($urandom_range(0, 15) == 0) ? height_t'($urandom_range(10, 15))
                                                  : height_t'($urandom_range(0, 9));
        1:       h = height_t'($urandom_range(0, 2));
        default: h = height_t'($urandom_range(0, 15));
      endcase
      queue_cell(h);
    end
  endtask

  initial begin : stimulus
    int unsigned mode, cols, rows, cells, frames, spill;
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = CFG_COLUMN_COUNT;
    cfg_data_i             = '0;
    height_ch.valid        = 1'b0;
    height_ch.height_value = '0;
    risk_ch.ready          = 1'b0;
    cycle_count            = 0;
    fail_count             = 0;
    cells_issued           = 0;
    feed_idle_en           = 1'b1;
    drain_idle_en          = 1'b1;
    foreach (line_one[i]) begin
      line_one[i] = 0;
      line_two[i] = 0;
    end
    eff_cols = clamp_count(CFG_RESET_COUNT, MAX_COLUMNS);
    eff_rows = clamp_count(CFG_RESET_COUNT, MAX_ROWS);
    restart_frame();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // partial frame at reset size, cut short by the next write
    queue_heights(5, 0);

    // 1x1 frames: every cell is a minimum; above-nine saturates
    configure(1'b1, 8'd1, 1'b1, 8'd1, 1'b0);
    queue_cell(4'd15);
    queue_cell(4'd0);
    queue_cell(4'd9);

    // 3x3: lone center pit, then four corner pits
    configure(1'b1, 8'd3, 1'b1, 8'd3, 1'b1);
    queue_cell(4'd9); queue_cell(4'd9); queue_cell(4'd9);
    queue_cell(4'd9); queue_cell(4'd0); queue_cell(4'd9);
    queue_cell(4'd9); queue_cell(4'd9); queue_cell(4'd9);
    queue_cell(4'd0); queue_cell(4'd5); queue_cell(4'd1);
    queue_cell(4'd5); queue_cell(4'd9); queue_cell(4'd5);
    queue_cell(4'd2); queue_cell(4'd5); queue_cell(4'd3);
    // partial frame, restarted by the write that follows
    queue_cell(4'd8); queue_cell(4'd3); queue_cell(4'd12); queue_cell(4'd4);

    // size extremes: zero acts as one, above the maximum clamps
    configure(1'b1, 8'd0, 1'b1, 8'd255, 1'b0);
    queue_heights(MAX_ROWS, 0);
    configure(1'b1, 8'd128, 1'b1, 8'd2, 1'b1);
    queue_heights(2 * MAX_COLUMNS, 2);
    configure(1'b1, 8'd255, 1'b1, 8'd0, 1'b0);
    queue_heights(MAX_COLUMNS, 1);

    // random frame shapes and contents
    while (cells_issued < CELL_TARGET) begin
      mode = $urandom_range(0, 3);
      cols = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 64 : 10);
      rows = $urandom_range(1, 8);
      if (mode == 2 && cols * eff_rows > 256) mode = 0;
      if (mode == 3 && eff_cols * rows > 256) mode = 1;
      configure(mode != 3, cfg_data_t'(cols), mode != 2, cfg_data_t'(rows), mode == 1);
      if (cells_issued > QUIET_TAIL) begin
        feed_idle_en  = 1'b0;
        drain_idle_en = 1'b0;
      end else begin
        feed_idle_en  = ($urandom_range(0, 3) != 0);
        drain_idle_en = ($urandom_range(0, 3) != 0);
      end
      cells  = eff_cols * eff_rows;
      frames = (cells > 64) ? 1 : $urandom_range(1, 3);
      spill  = (cells > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, cells - 1) : 0;
      queue_heights(frames * cells + spill, $urandom_range(0, 2));
    end

    settle();
    if (fail_count == 0) begin
      $display("tb_grid_local_minimum_risk_sum_top passed");
    end else begin
      $display("tb_grid_local_minimum_risk_sum_top failed");
    end
    $finish;
  end

endmodule
